// ----- design/ddo_pkg.sv -----
// ----------------------------------------------------------------------------
// ddo_pkg
// Types and constants shared by the odometry datapath.
// ----------------------------------------------------------------------------
package ddo_pkg;

   localparam int ATAN_LEN   = 24;
   localparam int INV_GAIN   = 9949;
   localparam int RADIUS_RST = 1966;

   typedef enum logic [1:0] {
      CSR_WHEEL_RADIUS = 2'd0
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_DONE
   } state_type;

   // arctangent of 2^-i, 2^32 per turn
   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] r;
      unique case (i)
         5'd0:  r = 32'd536870912;
         5'd1:  r = 32'd316933406;
         5'd2:  r = 32'd167458907;
         5'd3:  r = 32'd85004756;
         5'd4:  r = 32'd42667331;
         5'd5:  r = 32'd21354465;
         5'd6:  r = 32'd10680862;
         5'd7:  r = 32'd5340757;
         5'd8:  r = 32'd2670675;
         5'd9:  r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- design/ddo_serial_mul.sv -----
// ----------------------------------------------------------------------------
// ddo_serial_mul
// Shift-and-add signed multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ddo_serial_mul #(
   parameter int AW = 18,
   parameter int BW = 33
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [AW-1:0] a,
   input  logic signed [BW-1:0] b,
   output logic                 done,
   output logic signed [AW+BW-1:0] product
);
   localparam int PW = AW + BW;
   localparam int CW = $clog2(BW + 1);

   logic signed [PW-1:0] acc_ff, acc_in;
   logic signed [PW-1:0] mcand_ff, mcand_in;
   logic [BW-1:0]        mplier_ff, mplier_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = PW'(a);
         mplier_in = b;
         count_in  = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         // top bit of a two's complement multiplier has negative weight
         if (mplier_ff[0]) begin
            if (count_ff == CW'(BW - 1)) acc_in = acc_ff - mcand_ff;
            else                          acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         count_in  = count_ff + 1'b1;
         if (count_ff == CW'(BW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      count_ff  <= count_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

// ----- design/diff_drive_odometry.sv -----
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Dead-reckoning pose tracker for a differential-drive base.
// ----------------------------------------------------------------------------
// One tick is handled at a time. A tick runs CORDIC_STEPS CORDIC rotation
// steps, then four 18-by-33 bit-serial multiplies on the one shared serial
// multiplier (radius times cosine, that times the wheel sum, then the same for
// sine), then loads the output register. A new tick is taken only once the
// pose has been loaded and the datapath is back in idle. The output register
// holds one finished pose; the datapath only waits when the next pose is ready
// while the previous one has not yet been transferred.
module diff_drive_odometry #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] left_wheel_angle, [63:32] right_wheel_raw, [79:64] yaw_angle
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] x_position, [63:32] y_position, [79:64] heading
   output logic [79:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ddo_pkg::*;

   localparam int SW = $clog2(CORDIC_STEPS + 1);

   state_type state_ff, state_in;

   logic [15:0] radius_ff;
   logic [31:0] last_l_ff, last_r_ff;
   logic [15:0] last_yaw_ff, theta_ff;
   logic        first_ff;
   logic signed [31:0] pose_x_ff, pose_y_ff;
   logic signed [32:0] sum_ff;
   logic [15:0] dyaw_ff;
   logic signed [17:0] cx_ff, cy_ff;
   logic signed [31:0] cz_ff;
   logic        flip_ff;
   logic [SW-1:0] step_ff;
   logic        phase_ff; // 0: rc product, 1: step product
   logic        rsp_valid_ff;
   logic [79:0] rsp_data_ff;

   // serial multiplier
   logic               mul_start, mul_done;
   logic signed [17:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [50:0] mul_p;

   ddo_serial_mul #(.AW(18), .BW(33)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .product(mul_p)
   );

   wire csr_hit  = ({1'b0, csr_paddr[2]} == CSR_WHEEL_RADIUS);
   wire csr_wr   = csr_psel && csr_penable && csr_pwrite;
   wire req_xfer = req_tvalid && req_tready;
   // output register free for a new pose
   wire rsp_free = !rsp_valid_ff || rsp_tready;
   wire rsp_load = (state_ff == ST_DONE) && rsp_free;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? {16'd0, radius_ff} : 32'd0;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_xfer) state_in = ST_ROTATE;
         ST_ROTATE: if (step_ff == SW'(CORDIC_STEPS - 1)) state_in = ST_MUL_X;
         ST_MUL_X:  if (mul_done && phase_ff) state_in = ST_MUL_Y;
         ST_MUL_Y:  if (mul_done && phase_ff) state_in = ST_DONE;
         ST_DONE:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   logic signed [17:0] xs, ys, nx, ny, cordic_fin_x;
   logic signed [31:0] nz, at;

   // multiplier sequencing
   logic signed [50:0] rc_round, st_round;
   logic signed [36:0] rc16_w;
   logic signed [33:0] dstep;
   logic signed [17:0] trig;
   always_comb begin
      mul_start = 1'b0;
      trig      = (state_ff == ST_MUL_Y) ? cy_ff : cx_ff;
      mul_a     = trig;
      mul_b     = {17'd0, radius_ff};
      rc_round  = mul_p + 51'sd8192;
      st_round  = mul_p + 51'sd65536;
      rc16_w    = rc_round[50:14];
      dstep     = st_round[50:17];
      unique case (state_ff)
         ST_ROTATE: mul_start = (step_ff == SW'(CORDIC_STEPS - 1));
         ST_MUL_X, ST_MUL_Y: begin
            if (mul_done && !phase_ff) begin
               mul_start = 1'b1;
               mul_a = rc16_w[17:0];
               mul_b = sum_ff;
            end else if (mul_done && phase_ff && state_ff == ST_MUL_X) begin
               mul_start = 1'b1;
               mul_a = cy_ff;
               mul_b = {17'd0, radius_ff};
            end
         end
         default: ;
      endcase
      // rotate-to-mul_x start uses the final cosine, supplied below
      if (state_ff == ST_ROTATE) mul_a = cordic_fin_x;
   end

   // cordic iteration
   always_comb begin
      xs = cx_ff >>> step_ff;
      ys = cy_ff >>> step_ff;
      at = $signed(atan_turn(5'(step_ff)));
      if (!cz_ff[31]) begin
         nx = cx_ff - ys; ny = cy_ff + xs; nz = cz_ff - at;
      end else begin
         nx = cx_ff + ys; ny = cy_ff - xs; nz = cz_ff + at;
      end
      cordic_fin_x = flip_ff ? -nx : nx;
   end

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                  input logic signed [33:0] d);
      logic signed [34:0] s;
      s = 35'(p) + 35'(d);
      if (s > 35'sd2147483647)       return 32'sh7fffffff;
      else if (s < -35'sd2147483648) return 32'sh80000000;
      else                           return s[31:0];
   endfunction

   logic [31:0] in_l, in_r, dl, dr, ang;
   logic [15:0] in_yaw, dy_w;
   always_comb begin
      in_l   = req_tdata[31:0];
      in_r   = 32'd0 - req_tdata[63:32];
      in_yaw = req_tdata[79:64];
      dl     = in_l - last_l_ff;
      dr     = in_r - last_r_ff;
      dy_w   = first_ff ? 16'd0 : in_yaw - last_yaw_ff;
      ang    = {theta_ff, 16'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= 16'(RADIUS_RST);
         last_l_ff    <= '0;
         last_r_ff    <= '0;
         last_yaw_ff  <= '0;
         first_ff     <= 1'b1;
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         theta_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr && csr_hit) radius_ff <= csr_pwdata[15:0];
         if (rsp_load)                        rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (req_xfer) begin
               last_l_ff   <= in_l;
               last_r_ff   <= in_r;
               last_yaw_ff <= in_yaw;
               first_ff    <= 1'b0;
               sum_ff      <= 33'($signed(dl)) + 33'($signed(dr));
               dyaw_ff     <= dy_w;
               step_ff     <= '0;
               cx_ff       <= 18'(INV_GAIN);
               cy_ff       <= '0;
               if (ang >= 32'h40000000 && ang < 32'hC0000000) begin
                  flip_ff <= 1'b1;
                  cz_ff   <= $signed(ang - 32'h80000000);
               end else begin
                  flip_ff <= 1'b0;
                  cz_ff   <= $signed(ang);
               end
            end
            ST_ROTATE: begin
               step_ff  <= step_ff + 1'b1;
               phase_ff <= 1'b0;
               if (step_ff == SW'(CORDIC_STEPS - 1)) begin
                  cx_ff <= flip_ff ? -nx : nx;
                  cy_ff <= flip_ff ? -ny : ny;
               end else begin
                  cx_ff <= nx; cy_ff <= ny; cz_ff <= nz;
               end
            end
            ST_MUL_X, ST_MUL_Y: if (mul_done) begin
               phase_ff <= !phase_ff;
               if (phase_ff) begin
                  if (state_ff == ST_MUL_X) pose_x_ff <= sat_add(pose_x_ff, dstep);
                  else                       pose_y_ff <= sat_add(pose_y_ff, dstep);
               end
            end
            ST_DONE: if (rsp_free) begin
               theta_ff    <= theta_ff + dyaw_ff;
               rsp_data_ff <= {theta_ff + dyaw_ff, pose_y_ff, pose_x_ff};
            end
            default: ;
         endcase
      end
   end
endmodule

// ----- design/ddo_checker.sv -----
// ----------------------------------------------------------------------------
// ddo_checker
// Port-level checks for the odometry block.
// ----------------------------------------------------------------------------
module ddo_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic csr_pready
);
   // one tick in the datapath at a time
   a_one_tick: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("second tick taken");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");

   a_no_fast: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result too early");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");
endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .csr_pready(csr_pready)
);
